>>> src/sik_pkg.sv
// Shared types, constants and helper functions of the SCARA inverse kinematics core.
`timescale 1ns / 1ps
package sik_pkg;

  localparam int UNIT_FRAC       = 30;
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int ROUND_SH        = UNIT_FRAC - ANGLE_FRAC_BITS;

  localparam logic [2:0] REG_FIRST_LINK  = 3'd0;
  localparam logic [2:0] REG_SECOND_LINK = 3'd1;
  localparam logic [2:0] REG_VERT_OFFSET = 3'd2;
  localparam logic [2:0] REG_BASE_MIN    = 3'd3;
  localparam logic [2:0] REG_BASE_MAX    = 3'd4;
  localparam logic [2:0] REG_ELBOW_MIN   = 3'd5;
  localparam logic [2:0] REG_ELBOW_MAX   = 3'd6;

  typedef enum logic [1:0] {
    DS_DIV  = 2'b01,
    DS_SQRT = 2'b10
  } ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_req_t;

  function automatic logic [30:0] atan_tab(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd7;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [35:0] to_angle(input logic signed [35:0] z);
    logic signed [35:0] sum;
    sum = z + (36'sd1 <<< (ROUND_SH - 1));
    return sum >>> ROUND_SH;
  endfunction

endpackage

>>> src/sik_divsqrt.sv
// Iterative restoring divider and integer square root, one bit per cycle.
`timescale 1ns / 1ps
module sik_divsqrt (
  input  logic             clk,
  input  logic             rst,
  input  sik_pkg::ds_req_t req,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [31:0]      result
);
  import sik_pkg::*;

  logic        busy;
  ds_mode_t    mode;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] den;
  logic [63:0] acc;
  logic [63:0] bitv;
  logic [64:0] rem2;
  logic [63:0] trial;
  logic        last;

  assign rem2   = {rem, 1'b0};
  assign trial  = acc + bitv;
  assign last   = (mode == DS_DIV) ? (cnt == 5'(UNIT_FRAC - 1)) : (cnt == 5'd31);
  assign result = acc[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      mode <= DS_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.mode;
        cnt  <= '0;
        rem  <= a;
        den  <= b;
        acc  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (mode == DS_DIV) begin
          if (rem2 >= {1'b0, den}) begin
            rem <= 64'(rem2 - {1'b0, den});
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= rem2[63:0];
            acc <= {acc[62:0], 1'b0};
          end
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            acc <= (acc >> 1) + bitv;
          end else begin
            acc <= acc >> 1;
          end
          bitv <= bitv >> 2;
        end
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
    end
  end

endmodule

>>> src/sik_cordic.sv
// Iterative CORDIC vectoring unit that returns atan2 in Q4.30.
`timescale 1ns / 1ps
module sik_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] y_in,
  input  logic signed [63:0] x_in,
  output logic               done,
  output logic signed [33:0] angle
);
  import sik_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic signed [63:0] NORM_LIM = 64'sh0000_0100_0000_0000;
  localparam logic signed [33:0] HALF_PI  = 34'sd1686629713;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_ITER = 3'b100
  } cstate_t;

  cstate_t            st;
  logic signed [63:0] nx;
  logic signed [63:0] ny;
  logic signed [43:0] x;
  logic signed [43:0] y;
  logic signed [33:0] z;
  logic [CW-1:0]      i;
  logic               big;
  logic signed [43:0] xs;
  logic signed [43:0] ys;
  logic signed [33:0] step;

  assign big   = (nx >= NORM_LIM) || (nx <= -NORM_LIM) || (ny >= NORM_LIM) || (ny <= -NORM_LIM);
  assign xs    = x >>> i;
  assign ys    = y >>> i;
  assign step  = $signed({3'b000, atan_tab(5'(i))});
  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      unique case (st)
        C_IDLE: begin
          if (start) begin
            nx <= x_in;
            ny <= y_in;
            z  <= '0;
            if (x_in == 64'sd0 && y_in == 64'sd0) begin
              done <= 1'b1;
            end else begin
              st <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (big) begin
            nx <= nx >>> 1;
            ny <= ny >>> 1;
          end else begin
            if (nx < 0) begin
              if (ny >= 0) begin
                x <= 44'(ny);
                y <= 44'(-nx);
                z <= HALF_PI;
              end else begin
                x <= 44'(-ny);
                y <= 44'(nx);
                z <= -HALF_PI;
              end
            end else begin
              x <= 44'(nx);
              y <= 44'(ny);
            end
            i  <= '0;
            st <= C_ITER;
          end
        end
        C_ITER: begin
          if (y >= 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + step;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - step;
          end
          if (i == CW'(CORDIC_STEPS - 1)) begin
            st   <= C_IDLE;
            done <= 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

endmodule

>>> src/scara_inverse_kinematics_core.sv
// Top level of the SCARA two-link inverse kinematics core.
//
// An input item carries the target point, the wrist orientation and the
// present base and elbow angles. It is a transfer when in_valid is high and
// in_stall is low. The block then raises in_stall while it works through the
// item and lowers it again once the result is in the output register.
// A shared multiplier forms the squared terms, and a bit-serial unit does the
// 30-step divide and the 32-step square root. One CORDIC unit runs five atan2
// passes. The next item can be taken in the same cycle as the result appears.
// A result is a transfer when out_valid is high and out_stall is low. While
// the receiver stalls, the result holds and a new item is still taken; the
// block waits at its last step until the output register is free.
// Configuration writes use cfg_valid and cfg_ready, which is always high. The
// user must make them only while the block is idle, which it does not enforce.
// Reset restores the default link lengths and limits, clears the held angles
// and empties the output.
`timescale 1ns / 1ps
module scara_inverse_kinematics_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] wrist_target,
  input  logic signed [31:0] current_base,
  input  logic signed [31:0] current_elbow,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] base_angle,
  output logic signed [31:0] elbow_angle,
  output logic signed [31:0] wrist_angle,
  output logic signed [31:0] stroke,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import sik_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL   = 12'b0000_0000_0010,
    S_DCHK  = 12'b0000_0000_0100,
    S_DIV   = 12'b0000_0000_1000,
    S_SQMUL = 12'b0000_0001_0000,
    S_SQSUB = 12'b0000_0010_0000,
    S_SQRT  = 12'b0000_0100_0000,
    S_LMUL  = 12'b0000_1000_0000,
    S_CORD  = 12'b0001_0000_0000,
    S_EVAL  = 12'b0010_0000_0000,
    S_PICK  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [30:0]        l1;
  logic [30:0]        l2;
  logic signed [31:0] voff;
  logic signed [31:0] bmin;
  logic signed [31:0] bmax;
  logic signed [31:0] emin;
  logic signed [31:0] emax;

  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic signed [31:0] tz;
  logic signed [31:0] we;
  logic signed [31:0] cb;
  logic signed [31:0] ce;

  logic signed [31:0] held_base;
  logic signed [31:0] held_elbow;
  logic signed [31:0] held_wrist;

  logic [2:0]         mstep;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic [63:0]        p64;

  logic [63:0]        r2;
  logic [63:0]        ls;
  logic [63:0]        den;
  logic [63:0]        num;
  logic               neg;
  logic [30:0]        q;
  logic [30:0]        s;
  logic signed [31:0] c;
  logic signed [63:0] ax;
  logic signed [63:0] ay;

  ds_req_t            ds_req;
  logic [63:0]        ds_a;
  logic               ds_done;
  logic [31:0]        ds_res;

  logic [2:0]         crun;
  logic               cgo;
  logic               c_start;
  logic signed [63:0] c_y;
  logic signed [63:0] c_x;
  logic               c_done;
  logic signed [33:0] c_angle;
  logic signed [63:0] s64;

  logic signed [33:0] phi;
  logic signed [33:0] dk0;
  logic signed [33:0] dk1;
  logic signed [33:0] el0;
  logic signed [33:0] el1;
  logic signed [35:0] t1_0;
  logic signed [35:0] t1_1;
  logic signed [35:0] t2_0;
  logic signed [35:0] t2_1;
  logic               ok0;
  logic               ok1;
  logic signed [39:0] ch0;
  logic signed [39:0] ch1;
  logic signed [31:0] t3_0;
  logic signed [31:0] t3_1;
  logic               pick;
  logic               out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign p64       = prod[63:0];
  assign s64       = $signed({33'd0, s});
  assign out_free  = !out_valid || !out_stall;
  assign pick      = (ok0 && ok1) ? (ch0 > ch1) : !ok0;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MUL: begin
        case (mstep)
          3'd0: begin ma = 33'(tx); mb = 33'(tx); end
          3'd1: begin ma = 33'(ty); mb = 33'(ty); end
          3'd2: begin ma = $signed({2'b00, l1}); mb = $signed({2'b00, l1}); end
          3'd3: begin ma = $signed({2'b00, l2}); mb = $signed({2'b00, l2}); end
          default: begin ma = $signed({2'b00, l1}); mb = $signed({2'b00, l2}); end
        endcase
      end
      S_SQMUL: begin
        ma = $signed({2'b00, q});
        mb = $signed({2'b00, q});
      end
      S_LMUL: begin
        ma = $signed({2'b00, l2});
        if (mstep == 3'd0) begin
          mb = 33'(c);
        end else begin
          mb = $signed({2'b00, s});
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_comb begin
    ds_req.start = 1'b0;
    ds_req.mode  = DS_SQRT;
    ds_a         = 64'h1000_0000_0000_0000 - p64;
    if (state == S_DCHK) begin
      ds_req.start = !(den == 64'd0 || num >= den);
      ds_req.mode  = DS_DIV;
      ds_a         = num;
    end else if (state == S_SQSUB) begin
      ds_req.start = 1'b1;
    end
  end

  always_comb begin
    case (crun)
      3'd0: begin c_y = 64'(ty); c_x = 64'(tx); end
      3'd1: begin c_y = ay; c_x = ax; end
      3'd2: begin c_y = -ay; c_x = ax; end
      3'd3: begin c_y = s64; c_x = 64'(c); end
      default: begin c_y = -s64; c_x = 64'(c); end
    endcase
  end

  assign c_start = (state == S_CORD) && cgo;

  sik_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .req    (ds_req),
    .a      (ds_a),
    .b      (den),
    .done   (ds_done),
    .result (ds_res)
  );

  sik_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .angle (c_angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= 31'd13107200;
      l2 <= 31'd13107200;
      voff <= 32'sd0;
      bmin <= -32'sd52707179;
      bmax <= 32'sd52707179;
      emin <= -32'sd52707179;
      emax <= 32'sd52707179;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_LINK:  l1 <= cfg_data[30:0];
        REG_SECOND_LINK: l2 <= cfg_data[30:0];
        REG_VERT_OFFSET: voff <= cfg_data;
        REG_BASE_MIN:    bmin <= cfg_data;
        REG_BASE_MAX:    bmax <= cfg_data;
        REG_ELBOW_MIN:   emin <= cfg_data;
        REG_ELBOW_MAX:   emax <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mstep      <= '0;
      crun       <= '0;
      cgo        <= 1'b0;
      out_valid  <= 1'b0;
      held_base  <= '0;
      held_elbow <= '0;
      held_wrist <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tx    <= target_x;
            ty    <= target_y;
            tz    <= target_z;
            we    <= wrist_target;
            cb    <= current_base;
            ce    <= current_elbow;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: r2 <= p64;
            3'd2: r2 <= r2 + p64;
            3'd3: ls <= p64;
            3'd4: ls <= ls + p64;
            3'd5: begin
              den   <= {p64[62:0], 1'b0};
              neg   <= r2 < ls;
              num   <= (r2 < ls) ? ls - r2 : r2 - ls;
              state <= S_DCHK;
            end
            default: ;
          endcase
        end
        S_DCHK: begin
          if (den == 64'd0 || num >= den) begin
            q     <= 31'h4000_0000;
            state <= S_SQMUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ds_done) begin
            q     <= ds_res[30:0];
            state <= S_SQMUL;
          end
        end
        S_SQMUL: begin
          state <= S_SQSUB;
        end
        S_SQSUB: begin
          c     <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ds_done) begin
            s     <= ds_res[30:0];
            mstep <= '0;
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          mstep <= mstep + 3'd1;
          if (mstep == 3'd1) begin
            ax <= $signed({3'b000, l1, 30'd0}) + $signed(p64);
          end else if (mstep == 3'd2) begin
            ay    <= $signed(p64);
            crun  <= '0;
            cgo   <= 1'b1;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          cgo <= 1'b0;
          if (c_done) begin
            case (crun)
              3'd0: phi <= c_angle;
              3'd1: dk0 <= c_angle;
              3'd2: dk1 <= c_angle;
              3'd3: el0 <= c_angle;
              default: el1 <= c_angle;
            endcase
            if (crun == 3'd4) begin
              state <= S_EVAL;
            end else begin
              crun <= crun + 3'd1;
              cgo  <= 1'b1;
            end
          end
        end
        S_EVAL: begin
          t1_0  <= to_angle(36'(phi) - 36'(dk0));
          t1_1  <= to_angle(36'(phi) - 36'(dk1));
          t2_0  <= to_angle(36'(el0));
          t2_1  <= to_angle(36'(el1));
          state <= S_PICK;
        end
        S_PICK: begin
          ok0 <= (t1_0 >= bmin) && (t1_0 <= bmax) && (t2_0 >= emin) && (t2_0 <= emax);
          ok1 <= (t1_1 >= bmin) && (t1_1 <= bmax) && (t2_1 >= emin) && (t2_1 <= emax);
          ch0 <= ((40'(t1_0) - 40'(cb)) < 0 ? 40'(cb) - 40'(t1_0) : 40'(t1_0) - 40'(cb))
               + ((40'(t2_0) - 40'(ce)) < 0 ? 40'(ce) - 40'(t2_0) : 40'(t2_0) - 40'(ce));
          ch1 <= ((40'(t1_1) - 40'(cb)) < 0 ? 40'(cb) - 40'(t1_1) : 40'(t1_1) - 40'(cb))
               + ((40'(t2_1) - 40'(ce)) < 0 ? 40'(ce) - 40'(t2_1) : 40'(t2_1) - 40'(ce));
          t3_0 <= sat32(40'(we) - (40'(t1_0) + 40'(t2_0)));
          t3_1 <= sat32(40'(we) - (40'(t1_1) + 40'(t2_1)));
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (ok0 || ok1) begin
              held_base   <= sat32(40'(pick ? t1_1 : t1_0));
              held_elbow  <= sat32(40'(pick ? t2_1 : t2_0));
              held_wrist  <= pick ? t3_1 : t3_0;
              base_angle  <= sat32(40'(pick ? t1_1 : t1_0));
              elbow_angle <= sat32(40'(pick ? t2_1 : t2_0));
              wrist_angle <= pick ? t3_1 : t3_0;
              status      <= 1'b0;
            end else begin
              base_angle  <= held_base;
              elbow_angle <= held_elbow;
              wrist_angle <= held_wrist;
              status      <= 1'b1;
            end
            stroke    <= sat32(40'(voff) - 40'(tz));
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/sik_checker.sv
// Port-level assertions for the SCARA inverse kinematics core and their bind.
`timescale 1ns / 1ps
module sik_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] base_angle,
  input logic               status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(base_angle) && $stable(status))
    else $error("Stalled result changed before its transfer.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken again while an item is in progress.");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("New result shown while the core still reports busy.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Core not empty and idle after reset.");

endmodule

bind scara_inverse_kinematics_core sik_checker u_sik_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .base_angle (base_angle),
  .status     (status)
);
